// ===== design/u8dec_pkg.sv =====
// shared types and codes for the utf-8 byte stream decoder
package u8dec_pkg;

    localparam int CpWidth = 31;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // byte held in the input stage
    typedef struct packed {
        logic       valid;
        logic [7:0] byte_in;
    } u8dec_slot_t;

    // outcome of one decode step
    typedef struct packed {
        logic               emit;
        logic [CpWidth-1:0] code_point;
        logic [1:0]         status;
    } u8dec_res_t;

endpackage

// ===== design/utf8_byte_stream_decoder_core.sv =====
// Top level of the UTF-8 byte stream to UCS-4 decoder.
// One raw byte enters per item on the s_ channel (s_valid, s_ready,
// s_byte_in); decoded code points leave on the m_ channel (m_valid, m_ready,
// m_code_point, m_status) with status 0 ok, 1 stray continuation or bad
// lead byte, 2 sequence cut short by a zero byte.
// Lead bytes up to six-byte sequences are taken; continuation bytes only
// give their low six bits. Lead and inner bytes produce no result.
// A byte accepted into the input register is decoded there, and its result,
// if any, is loaded into the result register when the item moves on, which
// a receiver stall can hold back.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// state update between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to idle with no sequence open.
// When the receiver stalls with a result held, the byte in the input
// register waits, and s_ready stays high only while that register is empty;
// no result is lost or repeated.
module utf8_byte_stream_decoder_core
    import u8dec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CpWidth-1:0] m_code_point,
    output logic [1:0]         m_status
);

    u8dec_slot_t slot;
    u8dec_res_t  res;
    logic        advance;
    logic        load;

    // held item moves on when the result register can take it
    assign advance = slot.valid && (!m_valid || m_ready);
    assign load    = advance && res.emit;

    u8dec_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .advance   (advance),
        .slot      (slot)
    );

    u8dec_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .byte_in (slot.byte_in),
        .res     (res)
    );

    u8dec_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .res          (res),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_status     (m_status)
    );

    // error and truncated results always carry a zero code point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_code_point == '0)
        else $error("nonzero code point on error result");

    // an item with a result never moves on without reaching the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid && m_code_point == $past(res.code_point))
        else $error("result lost between stages");

    // an empty input register always takes an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !slot.valid |-> s_ready)
        else $error("input stage empty but not ready");

endmodule

// ===== design/u8dec_in_stage.sv =====
// input register stage holding one byte item
module u8dec_in_stage
    import u8dec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        advance,
    output u8dec_slot_t slot
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // room when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

    assign slot.valid   = valid_reg;
    assign slot.byte_in = byte_reg;

endmodule

// ===== design/u8dec_step.sv =====
// decode state and per-byte update logic
module u8dec_step
    import u8dec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] byte_in,
    output u8dec_res_t res
);

    logic [CpWidth-1:0] partial_value_reg;
    logic [CpWidth-1:0] partial_value_next;
    logic [2:0]         bytes_remaining_reg;
    logic [2:0]         bytes_remaining_next;
    logic [CpWidth-1:0] shifted;
    logic [2:0]         remaining_dec;

    assign shifted       = {partial_value_reg[CpWidth-7:0], byte_in[5:0]};
    assign remaining_dec = bytes_remaining_reg - 3'd1;

    // next state and result for the byte in the input stage
    always_comb begin
        partial_value_next   = partial_value_reg;
        bytes_remaining_next = bytes_remaining_reg;
        res.emit             = 1'b0;
        res.code_point       = '0;
        res.status           = ST_OK;
        if (bytes_remaining_reg != 3'd0) begin
            if (byte_in == 8'h00) begin
                // zero byte aborts the open sequence
                partial_value_next   = '0;
                bytes_remaining_next = 3'd0;
                res.emit             = 1'b1;
                res.status           = ST_TRUNC;
            end else if (remaining_dec == 3'd0) begin
                partial_value_next   = '0;
                bytes_remaining_next = 3'd0;
                res.emit             = 1'b1;
                res.code_point       = shifted;
            end else begin
                partial_value_next   = shifted;
                bytes_remaining_next = remaining_dec;
            end
        end else begin
            priority if (byte_in < 8'h80) begin
                res.emit       = 1'b1;
                res.code_point = {{(CpWidth-8){1'b0}}, byte_in};
            end else if (byte_in < 8'hC0 || byte_in >= 8'hFE) begin
                // stray continuation or invalid lead
                res.emit   = 1'b1;
                res.status = ST_BAD;
            end else if (byte_in < 8'hE0) begin
                partial_value_next   = {{(CpWidth-5){1'b0}}, byte_in[4:0]};
                bytes_remaining_next = 3'd1;
            end else if (byte_in < 8'hF0) begin
                partial_value_next   = {{(CpWidth-4){1'b0}}, byte_in[3:0]};
                bytes_remaining_next = 3'd2;
            end else if (byte_in < 8'hF8) begin
                partial_value_next   = {{(CpWidth-3){1'b0}}, byte_in[2:0]};
                bytes_remaining_next = 3'd3;
            end else if (byte_in < 8'hFC) begin
                partial_value_next   = {{(CpWidth-2){1'b0}}, byte_in[1:0]};
                bytes_remaining_next = 3'd4;
            end else begin
                partial_value_next   = {{(CpWidth-2){1'b0}}, byte_in[1:0]};
                bytes_remaining_next = 3'd5;
            end
        end
    end

    // state registers, updated only when an item moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_value_reg   <= '0;
            bytes_remaining_reg <= 3'd0;
        end else if (advance) begin
            partial_value_reg   <= partial_value_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

    // longest sequence leaves five continuation bytes due
    assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_remaining_reg <= 3'd5)
        else $error("continuation count out of range");

    // no gathered bits survive outside an open sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_remaining_reg == 3'd0 |-> partial_value_reg == '0)
        else $error("partial value left over while idle");

    // a zero byte inside a sequence closes it with a truncated result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && bytes_remaining_reg != 3'd0 && byte_in == 8'h00
        |-> res.emit && res.status == ST_TRUNC
        ##1 bytes_remaining_reg == 3'd0)
        else $error("zero byte did not abort the sequence");

endmodule

// ===== design/u8dec_out_stage.sv =====
// result register stage toward the receiver
module u8dec_out_stage
    import u8dec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  u8dec_res_t         res,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CpWidth-1:0] m_code_point,
    output logic [1:0]         m_status
);

    logic               valid_reg;
    logic               valid_next;
    logic [CpWidth-1:0] code_point_reg;
    logic [1:0]         status_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            code_point_reg <= res.code_point;
            status_reg     <= res.status;
        end
    end

    assign m_valid      = valid_reg;
    assign m_code_point = code_point_reg;
    assign m_status     = status_reg;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the utf-8 byte stream decoder core
module testbench;
    import u8dec_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int RandomItems = 1725;
    localparam int CalmItems   = 150;
    localparam int TailCycles  = 8;

    // one pending entry for the byte driver, or a pause until all results are in
    typedef struct {
        logic       hold;
        logic [7:0] value;
    } feed_t;

    // one decoded code point still awaited from the block
    typedef struct {
        logic [CpWidth-1:0] cp;
        logic [1:0]         st;
    } cp_exp_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_byte_in = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [CpWidth-1:0] m_code_point;
    logic [1:0]         m_status;

    feed_t   feed_q[$];
    cp_exp_t cp_pending[$];

    // decoder state kept by the predictor
    logic [CpWidth-1:0] seq_value = '0;
    logic [2:0]         cont_left = '0;

    int errors      = 0;
    int bytes_sent  = 0;
    int cps_checked = 0;
    int cycles      = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int status_seen[3];

    utf8_byte_stream_decoder_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_status     (m_status)
    );

    // clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void expect_cp(logic [CpWidth-1:0] cp, logic [1:0] st);
        cp_exp_t e;
        e.cp = cp;
        e.st = st;
        cp_pending.push_back(e);
    endfunction

    // predicted effect of one accepted byte on the decoder
    function automatic void decode_byte(logic [7:0] b);
        if (cont_left != 3'd0) begin
            if (b == 8'h00) begin
                // zero byte aborts an open sequence
                seq_value = '0;
                cont_left = 3'd0;
                expect_cp('0, ST_TRUNC);
            end else begin
                // any nonzero byte counts as continuation, low six bits only
                seq_value = {seq_value[CpWidth-7:0], b[5:0]};
                cont_left = cont_left - 3'd1;
                if (cont_left == 3'd0) begin
                    expect_cp(seq_value, ST_OK);
                    seq_value = '0;
                end
            end
        end else if (b < 8'h80) begin
            expect_cp({{(CpWidth-8){1'b0}}, b}, ST_OK);
        end else if (b < 8'hC0 || b >= 8'hFE) begin
            expect_cp('0, ST_BAD);
        end else if (b < 8'hE0) begin
            seq_value = {{(CpWidth-5){1'b0}}, b[4:0]};
            cont_left = 3'd1;
        end else if (b < 8'hF0) begin
            seq_value = {{(CpWidth-4){1'b0}}, b[3:0]};
            cont_left = 3'd2;
        end else if (b < 8'hF8) begin
            seq_value = {{(CpWidth-3){1'b0}}, b[2:0]};
            cont_left = 3'd3;
        end else if (b < 8'hFC) begin
            seq_value = {{(CpWidth-2){1'b0}}, b[1:0]};
            cont_left = 3'd4;
        end else begin
            seq_value = {{(CpWidth-2){1'b0}}, b[1:0]};
            cont_left = 3'd5;
        end
    endfunction

    task automatic report_mismatch(string what, logic [CpWidth-1:0] got,
                                   logic [CpWidth-1:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycles, what, got, want);
        errors++;
    endtask

    // byte driver
    always @(posedge aclk) begin : drive_proc
        logic       fired;
        logic       nv;
        logic [7:0] nb;
        feed_t      f;
        fired = s_valid && s_ready;
        nv    = s_valid;
        nb    = s_byte_in;
        if (!aresetn) begin
            nv = 1'b0;
        end else begin
            if (fired) begin
                decode_byte(s_byte_in);
                bytes_sent++;
            end
            if (!s_valid || fired) begin
                nv = 1'b0;
                if (feed_q.size() > 0 && feed_q[0].hold) begin
                    if (cp_pending.size() == 0) void'(feed_q.pop_front());
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_q.size() >= CalmItems && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 5) - 1;
                end else if (feed_q.size() > 0) begin
                    f  = feed_q.pop_front();
                    nv = 1'b1;
                    nb = f.value;
                end
            end
        end
        s_valid   <= nv;
        s_byte_in <= nb;
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin : watch_proc
        logic    nr;
        cp_exp_t e;
        nr = m_ready;
        if (!aresetn) begin
            nr = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cp_pending.size() == 0) begin
                    report_mismatch("unexpected item, code point", m_code_point, '0);
                end else begin
                    e = cp_pending.pop_front();
                    if (m_code_point !== e.cp)
                        report_mismatch("code point", m_code_point, e.cp);
                    if (m_status !== e.st)
                        report_mismatch("status", {{(CpWidth-2){1'b0}}, m_status},
                                        {{(CpWidth-2){1'b0}}, e.st});
                    if (e.st <= ST_TRUNC) status_seen[e.st]++;
                    cps_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                nr = 1'b0;
            end else if (feed_q.size() >= CalmItems && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
        end
        m_ready <= nr;
    end

    function automatic void add_byte(logic [7:0] b);
        feed_t f;
        f.hold  = 1'b0;
        f.value = b;
        feed_q.push_back(f);
    endfunction

    function automatic void add_hold();
        feed_t f;
        f.hold  = 1'b1;
        f.value = 8'h00;
        feed_q.push_back(f);
    endfunction

    // lead byte for a sequence of len bytes in total (2 to 6)
    function automatic logic [7:0] lead_for(int len);
        case (len)
            2: return 8'($urandom_range(8'hC0, 8'hDF));
            3: return 8'($urandom_range(8'hE0, 8'hEF));
            4: return 8'($urandom_range(8'hF0, 8'hF7));
            5: return 8'($urandom_range(8'hF8, 8'hFB));
            default: return 8'($urandom_range(8'hFC, 8'hFD));
        endcase
    endfunction

    // continuation byte, now and then any nonzero byte
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic int add_stream_part();
        int kind;
        int len;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            // complete multi-byte sequence
            len = $urandom_range(2, 6);
            add_byte(lead_for(len));
            for (int i = 1; i < len; i++) add_byte(cont_byte());
            return len;
        end else if (kind < 72) begin
            add_byte(8'($urandom_range(1, 8'h7F)));
            return 1;
        end else if (kind < 82) begin
            // sequence cut short by a zero byte
            len = $urandom_range(2, 6);
            cut = $urandom_range(1, len - 1);
            add_byte(lead_for(len));
            for (int i = 1; i < cut; i++) add_byte(cont_byte());
            add_byte(8'h00);
            return cut + 1;
        end else if (kind < 90) begin
            // stray continuation or invalid lead
            if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(8'hFE, 8'hFF)));
            else add_byte(8'($urandom_range(8'h80, 8'hBF)));
            return 1;
        end else begin
            add_byte(8'($urandom_range(0, 255)));
            return 1;
        end
    endfunction

    initial begin : main_proc
        logic [7:0] directed[] = '{
            8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
            8'hC0, 8'h80,
            8'hEF, 8'hBF, 8'hBF,
            8'hF7, 8'hBF, 8'hBF, 8'hBF,
            8'hE2, 8'h00,
            8'hD0, 8'h41,
            8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF
        };
        int added;
        foreach (directed[i]) add_byte(directed[i]);
        add_hold();
        added = 0;
        while (added < RandomItems) begin
            added += add_stream_part();
            if (added >= RandomItems / 2 && added < RandomItems / 2 + 6) add_hold();
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for all bytes taken and every result seen
        while (feed_q.size() > 0 || s_valid || cp_pending.size() > 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        $display("decoded %0d bytes into %0d results over %0d cycles",
                 bytes_sent, cps_checked, cycles);
        $display("results: %0d ok, %0d stray or invalid, %0d truncated",
                 status_seen[ST_OK], status_seen[ST_BAD], status_seen[ST_TRUNC]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
